@@ design/qslerp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the quaternion slerp pipeline.
// No dependencies; every other file of the block imports this package.
package qslerp_pkg;

  // Fixed-point constants.
  localparam logic [14:0] ONE_Q14      = 15'd16384;
  localparam logic [28:0] ONE_Q28      = 29'd268435456;
  localparam logic [16:0] HALF_PI_ANG  = 17'd65536;
  localparam logic [14:0] THRESH_RESET = 15'd16376;
  localparam logic signed [31:0] CORDIC_K = 32'sd163008219;
  localparam logic signed [47:0] ROUND_Q28 = 48'sd134217728;
  localparam int CORDIC_STEPS = 16;

  // Arctangent table in binary angle units, pi/2 = 65536.
  localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
    17'd32768, 17'd19344, 17'd10221, 17'd5188, 17'd2604, 17'd1303, 17'd652, 17'd326,
    17'd163, 17'd81, 17'd41, 17'd20, 17'd10, 17'd5, 17'd3, 17'd1
  };

  // Stage counts of the pipeline sections.
  localparam int FRONT_STAGES  = 7;
  localparam int SQRT_STAGES   = 15;
  localparam int CORDIC_STAGES = 35;
  localparam int DIV_STAGES    = 16;
  localparam int BACK_STAGES   = 3;

  // Everything one transaction carries from stage to stage.
  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [14:0]      t;
    logic [3:0][33:0] mul;
    logic [33:0]      dot;
    logic             lin;
    logic [28:0]      c;
    logic [56:0]      csq;
    logic [3:0][16:0] l;
    logic [59:0]      sq_in;
    logic [31:0]      sq_rem;
    logic [29:0]      sq_root;
    logic [31:0]      cx;
    logic [31:0]      cy;
    logic [17:0]      cz;
    logic [16:0]      th;
    logic [1:0][31:0] sx;
    logic [1:0][31:0] sy;
    logic [1:0][17:0] sz;
    logic [3:0][31:0] dv_rem;
    logic [3:0][30:0] dv_d;
    logic [3:0][28:0] dv_q;
    logic [3:0]       dv_ovf;
    logic [28:0]      w0;
    logic [28:0]      w1;
    logic [3:0][47:0] wa;
    logic [3:0][47:0] wb;
    logic [3:0][15:0] r;
  } pipe_t;

  // Saturate a signed value to 16 bits.
  function automatic logic [15:0] sat16(input logic signed [47:0] v);
    logic [15:0] res;
    if (v > 48'sd32767) begin
      res = 16'h7fff;
    end else if (v < -48'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

@@ design/qslerp_front.sv @@
`timescale 1ns / 1ps
// Front stages: dot product, shorter-arc fold, path select, linear blend and squares.
// Depends on qslerp_pkg.
module qslerp_front import qslerp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [14:0] thresh,
  input  logic        in_valid,
  output logic        in_ready,
  input  pipe_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pipe_t       out_data
);

  localparam int NS = FRONT_STAGES;

  logic        stage_valid [NS];
  pipe_t       stage_data  [NS];
  logic [NS:0] advance;

  function automatic pipe_t step(input int k, input pipe_t p, input logic [14:0] thr);
    pipe_t q;
    logic signed [33:0] ea;
    logic signed [33:0] eb;
    logic signed [33:0] acc;
    logic signed [17:0] diff;
    logic [57:0] csq_w;
    logic [32:0] m2;
    q = p;
    acc = '0;
    m2 = '0;
    case (k)
      0: begin
        for (int i = 0; i < 4; i++) begin
          ea = $signed(p.a[i]);
          eb = $signed(p.b[i]);
          q.mul[i] = ea * eb;
        end
      end
      1: begin
        for (int i = 0; i < 4; i++) begin
          acc = acc + $signed(p.mul[i]);
        end
        q.dot = acc;
      end
      2: begin
        // Fold onto the shorter arc, then choose the path.
        acc = $signed(p.dot);
        if (acc < 0) begin
          acc = -acc;
          for (int i = 0; i < 4; i++) begin
            q.b[i] = -p.b[i];
          end
        end
        q.dot = acc;
        q.lin = acc > $signed({5'b0, thr, 14'b0});
        q.c = (acc > $signed({5'b0, ONE_Q28})) ? ONE_Q28 : acc[28:0];
      end
      3: begin
        for (int i = 0; i < 4; i++) begin
          diff = $signed(p.b[i]) - $signed(p.a[i]);
          ea = diff;
          eb = $signed({1'b0, p.t});
          q.mul[i] = ea * eb;
        end
        csq_w = p.c * p.c;
        q.csq = csq_w[56:0];
      end
      4: begin
        for (int i = 0; i < 4; i++) begin
          ea = $signed(p.mul[i]) >>> 14;
          eb = $signed(p.a[i]);
          acc = ea + eb;
          q.l[i] = acc[16:0];
        end
      end
      5: begin
        for (int i = 0; i < 4; i++) begin
          ea = $signed(p.l[i]);
          q.mul[i] = ea * ea;
        end
      end
      6: begin
        // Square root operand: magnitude squared, or one minus cosine squared.
        for (int i = 0; i < 4; i++) begin
          m2 = m2 + p.mul[i][32:0];
        end
        q.sq_in = p.lin ? {27'b0, m2} : {3'b0, {1'b1, 56'b0} - p.csq};
        q.sq_rem = '0;
        q.sq_root = '0;
      end
      default: begin
        q = p;
      end
    endcase
    return q;
  endfunction

  assign advance[NS] = out_ready;
  assign in_ready    = advance[0];
  assign out_valid   = stage_valid[NS-1];
  assign out_data    = stage_data[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pipe_t prev;
    logic  prev_valid;
    if (k == 0) begin : g_first
      assign prev       = in_data;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev       = stage_data[k-1];
      assign prev_valid = stage_valid[k-1];
    end

    // A stage moves when it is empty or its successor moves.
    assign advance[k] = !stage_valid[k] || advance[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance[k]) begin
        stage_valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance[k]) begin
        stage_data[k] <= step(k, prev, thresh);
      end
    end
  end

endmodule

@@ design/qslerp_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, two result bits per stage.
// Depends on qslerp_pkg.
module qslerp_isqrt import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  localparam int NS = SQRT_STAGES;

  logic        stage_valid [NS];
  pipe_t       stage_data  [NS];
  logic [NS:0] advance;

  // Each stage brings in two pairs of operand bits.
  function automatic pipe_t step(input pipe_t p);
    pipe_t q;
    logic [33:0] rem_w;
    logic [33:0] trial;
    q = p;
    for (int j = 0; j < 2; j++) begin
      rem_w = {q.sq_rem, q.sq_in[59:58]};
      trial = {2'b0, q.sq_root, 2'b01};
      if (rem_w >= trial) begin
        rem_w = rem_w - trial;
        q.sq_root = {q.sq_root[28:0], 1'b1};
      end else begin
        q.sq_root = {q.sq_root[28:0], 1'b0};
      end
      q.sq_rem = rem_w[31:0];
      q.sq_in = {q.sq_in[57:0], 2'b00};
    end
    return q;
  endfunction

  assign advance[NS] = out_ready;
  assign in_ready    = advance[0];
  assign out_valid   = stage_valid[NS-1];
  assign out_data    = stage_data[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pipe_t prev;
    logic  prev_valid;
    if (k == 0) begin : g_first
      assign prev       = in_data;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev       = stage_data[k-1];
      assign prev_valid = stage_valid[k-1];
    end

    assign advance[k] = !stage_valid[k] || advance[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance[k]) begin
        stage_valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance[k]) begin
        stage_data[k] <= step(prev);
      end
    end
  end

endmodule

@@ design/qslerp_cordic.sv @@
`timescale 1ns / 1ps
// CORDIC stages: vectoring for the arc angle, sub-angle scaling, and two rotation lanes
// for the sines of the sub-angles, one iteration per stage. Depends on qslerp_pkg.
module qslerp_cordic import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  localparam int NS = CORDIC_STAGES;
  localparam int ROT_START = CORDIC_STEPS + 3;

  logic        stage_valid [NS];
  pipe_t       stage_data  [NS];
  logic [NS:0] advance;

  function automatic pipe_t step(input int k, input pipe_t p);
    pipe_t q;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [17:0] z;
    logic signed [17:0] ang;
    int i;
    q = p;
    if (k < CORDIC_STEPS) begin
      // Vectoring: drive y to zero, accumulate the angle.
      i = k;
      if (k == 0) begin
        x = $signed({3'b0, p.c});
        y = $signed({2'b0, p.sq_root});
        z = '0;
      end else begin
        x = $signed(p.cx);
        y = $signed(p.cy);
        z = $signed(p.cz);
      end
      ang = $signed({1'b0, ATAN_TAB[i]});
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ang;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ang;
      end
      q.cx = x;
      q.cy = y;
      q.cz = z;
    end else if (k == CORDIC_STEPS) begin
      // Clamp the angle to a quarter turn.
      z = $signed(p.cz);
      if (z < 0) begin
        q.th = '0;
      end else if (z > $signed({1'b0, HALF_PI_ANG})) begin
        q.th = HALF_PI_ANG;
      end else begin
        q.th = p.cz[16:0];
      end
    end else if (k == CORDIC_STEPS + 1) begin
      q.mul[0] = 34'((ONE_Q14 - p.t) * 32'(p.th));
      q.mul[1] = 34'(p.t * 32'(p.th));
    end else if (k == CORDIC_STEPS + 2) begin
      for (int n = 0; n < 2; n++) begin
        q.sz[n] = $signed({1'b0, p.mul[n][30:14]});
        q.sx[n] = CORDIC_K;
        q.sy[n] = '0;
      end
    end else begin
      // Rotation: two lanes, one per sub-angle.
      i = k - ROT_START;
      ang = $signed({1'b0, ATAN_TAB[i]});
      for (int n = 0; n < 2; n++) begin
        x = $signed(p.sx[n]);
        y = $signed(p.sy[n]);
        z = $signed(p.sz[n]);
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ang;
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ang;
        end
        q.sx[n] = x;
        q.sy[n] = y;
        q.sz[n] = z;
      end
    end
    return q;
  endfunction

  assign advance[NS] = out_ready;
  assign in_ready    = advance[0];
  assign out_valid   = stage_valid[NS-1];
  assign out_data    = stage_data[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pipe_t prev;
    logic  prev_valid;
    if (k == 0) begin : g_first
      assign prev       = in_data;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev       = stage_data[k-1];
      assign prev_valid = stage_valid[k-1];
    end

    assign advance[k] = !stage_valid[k] || advance[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance[k]) begin
        stage_valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance[k]) begin
        stage_data[k] <= step(k, prev);
      end
    end
  end

endmodule

@@ design/qslerp_div.sv @@
`timescale 1ns / 1ps
// Four pipelined restoring divider lanes, up to two quotient bits per stage. They form the
// slerp weights or the normalized components of the linear path. Depends on qslerp_pkg.
module qslerp_div import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  localparam int NS = DIV_STAGES;
  localparam int QBITS = 29;

  logic        stage_valid [NS];
  pipe_t       stage_data  [NS];
  logic [NS:0] advance;

  function automatic pipe_t step(input int k, input pipe_t p);
    pipe_t q;
    logic [29:0] num;
    logic [30:0] den;
    logic [16:0] mag;
    logic signed [31:0] sv;
    logic signed [16:0] lv;
    logic [31:0] rem;
    logic bit_q;
    int j;
    q = p;
    if (k == 0) begin
      // Operand setup: quotient = num * 2^28 / den.
      for (int n = 0; n < 4; n++) begin
        if (p.lin) begin
          lv = $signed(p.l[n]);
          mag = (lv < 0) ? 17'(-lv) : p.l[n];
          num = {13'b0, mag};
          den = {p.sq_root[16:0], 14'b0};
        end else if (n < 2) begin
          sv = $signed(p.sy[n]);
          num = (sv < 0) ? 30'd0 : p.sy[n][29:0];
          den = {2'b0, p.sq_root[28:0]};
        end else begin
          num = '0;
          den = 31'd1;
        end
        q.dv_ovf[n] = {2'b0, num} >= {den, 1'b0};
        q.dv_rem[n] = {2'b0, num};
        q.dv_d[n] = den;
        q.dv_q[n] = '0;
      end
    end else begin
      for (int jj = 0; jj < 2; jj++) begin
        j = 2 * (k - 1) + jj;
        if (j < QBITS) begin
          for (int n = 0; n < 4; n++) begin
            rem = q.dv_rem[n];
            if (j > 0) begin
              rem = {rem[30:0], 1'b0};
            end
            bit_q = rem >= {1'b0, q.dv_d[n]};
            if (bit_q) begin
              rem = rem - {1'b0, q.dv_d[n]};
            end
            q.dv_rem[n] = rem;
            q.dv_q[n] = {q.dv_q[n][27:0], bit_q};
          end
        end
      end
    end
    return q;
  endfunction

  assign advance[NS] = out_ready;
  assign in_ready    = advance[0];
  assign out_valid   = stage_valid[NS-1];
  assign out_data    = stage_data[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pipe_t prev;
    logic  prev_valid;
    if (k == 0) begin : g_first
      assign prev       = in_data;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev       = stage_data[k-1];
      assign prev_valid = stage_valid[k-1];
    end

    assign advance[k] = !stage_valid[k] || advance[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance[k]) begin
        stage_valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance[k]) begin
        stage_data[k] <= step(k, prev);
      end
    end
  end

endmodule

@@ design/qslerp_back.sv @@
`timescale 1ns / 1ps
// Back stages: weight selection, weighted sum, rounding and saturation; the last stage
// is the output register. Depends on qslerp_pkg.
module qslerp_back import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  pipe_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_data
);

  localparam int NS = BACK_STAGES;

  logic        stage_valid [NS];
  pipe_t       stage_data  [NS];
  logic [NS:0] advance;

  function automatic logic [28:0] clamp_w(input logic ovf, input logic [28:0] qv);
    return (ovf || (qv > ONE_Q28)) ? ONE_Q28 : qv;
  endfunction

  function automatic pipe_t step(input int k, input pipe_t p);
    pipe_t q;
    logic zero_root;
    logic signed [30:0] qs;
    logic signed [47:0] wide;
    logic signed [47:0] ew;
    logic signed [47:0] ex;
    q = p;
    zero_root = (p.sq_root == '0);
    case (k)
      0: begin
        // Linear path result, or the trig weights.
        for (int i = 0; i < 4; i++) begin
          qs = $signed({2'b0, p.dv_q[i]});
          if (p.l[i][16]) begin
            qs = -qs;
          end
          wide = qs;
          q.r[i] = zero_root ? 16'd0 : sat16(wide);
        end
        if (zero_root) begin
          // Sine of the arc is zero: plain linear weights.
          q.w0 = {ONE_Q14 - p.t, 14'b0};
          q.w1 = {p.t, 14'b0};
        end else begin
          q.w0 = clamp_w(p.dv_ovf[0], p.dv_q[0]);
          q.w1 = clamp_w(p.dv_ovf[1], p.dv_q[1]);
        end
      end
      1: begin
        for (int i = 0; i < 4; i++) begin
          ew = $signed({1'b0, p.w0});
          ex = $signed(p.a[i]);
          q.wa[i] = ew * ex;
          ew = $signed({1'b0, p.w1});
          ex = $signed(p.b[i]);
          q.wb[i] = ew * ex;
        end
      end
      2: begin
        if (!p.lin) begin
          for (int i = 0; i < 4; i++) begin
            wide = $signed(p.wa[i]) + $signed(p.wb[i]) + ROUND_Q28;
            wide = wide >>> 28;
            q.r[i] = sat16(wide);
          end
        end
      end
      default: begin
        q = p;
      end
    endcase
    return q;
  endfunction

  assign advance[NS] = out_ready;
  assign in_ready    = advance[0];
  assign out_valid   = stage_valid[NS-1];
  assign out_data    = stage_data[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pipe_t prev;
    logic  prev_valid;
    if (k == 0) begin : g_first
      assign prev       = in_data;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev       = stage_data[k-1];
      assign prev_valid = stage_valid[k-1];
    end

    assign advance[k] = !stage_valid[k] || advance[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[k] <= 1'b0;
      end else if (advance[k]) begin
        stage_valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance[k]) begin
        stage_data[k] <= step(k, prev);
      end
    end
  end

endmodule

@@ design/quaternion_slerp_top.sv @@
`timescale 1ns / 1ps
// Quaternion slerp, Q2.14 in and out. An accepted input transaction reaches its result
// through the pipeline stages (7 front, 15 square root, 35 CORDIC, 16 divider, 3 back).
// Throughput is one transaction per cycle while out_ready is high; every stage advances
// when it is empty or its successor advances, so bubbles close up while the output waits.
// Synchronous active-high reset empties the pipeline and sets the threshold to 16376.
module quaternion_slerp_top import qslerp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [14:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] b_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic [14:0]        interp_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] r_w,
  output logic signed [15:0] r_x,
  output logic signed [15:0] r_y,
  output logic signed [15:0] r_z
);

  logic [14:0] thresh;
  pipe_t in_pipe;
  pipe_t front_data, sqrt_data, cordic_data, div_data, back_data;
  logic  front_valid, sqrt_valid, cordic_valid, div_valid;
  logic  sqrt_ready, cordic_ready, div_ready, back_ready;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh <= cfg_wr_data;
    end
  end

  // Pack the input transaction; the weight is clamped to one.
  always_comb begin
    in_pipe = '0;
    in_pipe.a[0] = a_w;
    in_pipe.a[1] = a_x;
    in_pipe.a[2] = a_y;
    in_pipe.a[3] = a_z;
    in_pipe.b[0] = {b_w[15], b_w};
    in_pipe.b[1] = {b_x[15], b_x};
    in_pipe.b[2] = {b_y[15], b_y};
    in_pipe.b[3] = {b_z[15], b_z};
    in_pipe.t = (interp_t > ONE_Q14) ? ONE_Q14 : interp_t;
  end

  qslerp_front u_front (
    .clk(clk), .rst(rst), .thresh(thresh),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_pipe),
    .out_valid(front_valid), .out_ready(sqrt_ready), .out_data(front_data)
  );

  qslerp_isqrt u_isqrt (
    .clk(clk), .rst(rst),
    .in_valid(front_valid), .in_ready(sqrt_ready), .in_data(front_data),
    .out_valid(sqrt_valid), .out_ready(cordic_ready), .out_data(sqrt_data)
  );

  qslerp_cordic u_cordic (
    .clk(clk), .rst(rst),
    .in_valid(sqrt_valid), .in_ready(cordic_ready), .in_data(sqrt_data),
    .out_valid(cordic_valid), .out_ready(div_ready), .out_data(cordic_data)
  );

  qslerp_div u_div (
    .clk(clk), .rst(rst),
    .in_valid(cordic_valid), .in_ready(div_ready), .in_data(cordic_data),
    .out_valid(div_valid), .out_ready(back_ready), .out_data(div_data)
  );

  qslerp_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(div_valid), .in_ready(back_ready), .in_data(div_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(back_data)
  );

  assign r_w = back_data.r[0];
  assign r_x = back_data.r[1];
  assign r_y = back_data.r[2];
  assign r_z = back_data.r[3];

endmodule

@@ tb/quaternion_slerp_checker.sv @@
`timescale 1ns / 1ps
// Checker for the quaternion slerp block: watches both channels and the threshold port,
// predicts every result from the accepted inputs and compares it. Uses qslerp_pkg.
module quaternion_slerp_checker import qslerp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [14:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] b_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic [14:0]        interp_t,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] r_w,
  input  logic signed [15:0] r_x,
  input  logic signed [15:0] r_y,
  input  logic signed [15:0] r_z,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [15:0] q [4];
  } quat_t;

  quat_t       expected_quats [$];
  logic [14:0] thresh;

  localparam longint Q14 = 64'sd16384;
  localparam longint Q28 = 64'sd268435456;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Vectoring CORDIC: angle of (x, y) in binary angle units.
  function automatic longint arc_angle(input longint x, input longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  // Rotation CORDIC: sine in Q.28 of a binary angle.
  function automatic longint arc_sine(input longint z);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = longint'(CORDIC_K);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
      end
    end
    return y;
  endfunction

  function automatic longint sine_ratio(input longint sn, input longint st);
    longint w;
    if (sn < 0) sn = 0;
    w = (sn * Q28) / st;
    return (w > Q28) ? Q28 : w;
  endfunction

  // Full slerp of one input transaction.
  function automatic quat_t slerp_predict(input logic [7:0][15:0] comps, input logic [14:0] tin,
                                          input logic [14:0] thr);
    quat_t  res;
    longint qa [4];
    longint qb [4];
    longint lv [4];
    longint dot;
    longint t;
    longint c;
    longint st;
    longint th;
    longint w0;
    longint w1;
    longint unsigned m2;
    longint unsigned s;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      qa[i] = longint'($signed(comps[i]));
      qb[i] = longint'($signed(comps[4 + i]));
      dot = dot + qa[i] * qb[i];
    end
    t = longint'(tin);
    if (t > Q14) t = Q14;
    // Take the shorter arc.
    if (dot < 0) begin
      for (int i = 0; i < 4; i++) qb[i] = -qb[i];
      dot = -dot;
    end
    if (dot > longint'(thr) * Q14) begin
      // Near parallel: linear blend, then normalize.
      m2 = 0;
      for (int i = 0; i < 4; i++) begin
        lv[i] = qa[i] + ((t * (qb[i] - qa[i])) >>> 14);
        m2 = m2 + longint'(lv[i] * lv[i]);
      end
      s = int_sqrt(m2);
      for (int i = 0; i < 4; i++)
        res.q[i] = (s == 0) ? 16'h0000 : clip16((lv[i] * Q14) / longint'(s));
    end else begin
      c = (dot > Q28) ? Q28 : dot;
      st = longint'(int_sqrt((64'd1 << 56) - longint'(c * c)));
      if (st == 0) begin
        // Zero sine: plain weights without normalization.
        w0 = (Q14 - t) * Q14;
        w1 = t * Q14;
      end else begin
        th = arc_angle(c, st);
        if (th < 0) th = 0;
        if (th > 65536) th = 65536;
        w0 = sine_ratio(arc_sine(((Q14 - t) * th) >>> 14), st);
        w1 = sine_ratio(arc_sine((t * th) >>> 14), st);
      end
      for (int i = 0; i < 4; i++)
        res.q[i] = clip16((w0 * qa[i] + w1 * qb[i] + Q28 / 2) >>> 28);
    end
    return res;
  endfunction

  assign pending = expected_quats.size();

  // Track the threshold, predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    quat_t got;
    quat_t exp_q;
    if (rst) begin
      thresh <= THRESH_RESET;
      expected_quats.delete();
    end else begin
      if (cfg_wr_en) thresh <= cfg_wr_data;
      if (in_valid && in_ready)
        expected_quats.push_back(slerp_predict({b_z, b_y, b_x, b_w, a_z, a_y, a_x, a_w},
                                               interp_t, thresh));
      if (out_valid && out_ready) begin
        got.q[0] = r_w; got.q[1] = r_x; got.q[2] = r_y; got.q[3] = r_z;
        if (expected_quats.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result %h %h %h %h", $realtime,
                     r_w, r_x, r_y, r_z);
          fail_count = fail_count + 1;
        end else begin
          exp_q = expected_quats.pop_front();
          if (got.q != exp_q.q) begin
            if (fail_count < 10)
              $display("%0t: mismatch expected %h %h %h %h actual %h %h %h %h", $realtime,
                       exp_q.q[0], exp_q.q[1], exp_q.q[2], exp_q.q[3],
                       got.q[0], got.q[1], got.q[2], got.q[3]);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

@@ tb/tb_quaternion_slerp_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the quaternion slerp block: clock, reset, stimulus and verdict.
// Depends on qslerp_pkg, quaternion_slerp_top and quaternion_slerp_checker.
module tb_quaternion_slerp_top import qslerp_pkg::*;;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [14:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
  logic signed [15:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
  logic [14:0]        interp_t = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic signed [15:0] r_w, r_x, r_y, r_z;
  int                 fail_count;
  int                 pending;

  bit hold_req = 0;
  bit hold_done = 0;
  bit no_gaps = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always #5 clk = ~clk;

  quaternion_slerp_top dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z), .interp_t(interp_t),
    .out_valid(out_valid), .out_ready(out_ready),
    .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z)
  );

  quaternion_slerp_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z), .interp_t(interp_t),
    .out_valid(out_valid), .out_ready(out_ready),
    .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: stall pattern rotates through three modes, plus one long hold-off.
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc = cyc + 1;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end else begin
        mode = (cyc / 300) % 3;
        if (mode == 0) out_ready <= 1'b1;
        else if (mode == 1) out_ready <= ($urandom_range(0, 1) == 1);
        else out_ready <= ($urandom_range(0, 9) != 0);
      end
    end
  end

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Offer one input transaction and wait for it to be taken; then maybe idle.
  task automatic send_item(input logic [7:0][15:0] q, input logic [14:0] t);
    in_valid <= 1'b1;
    a_w <= q[0]; a_x <= q[1]; a_y <= q[2]; a_z <= q[3];
    b_w <= q[4]; b_x <= q[5]; b_y <= q[6]; b_z <= q[7];
    interp_t <= t;
    do @(posedge clk); while (!in_ready);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  endtask

  task automatic write_thresh(input logic [14:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Roughly unit quaternion scaled by s.
  task automatic unit_quat(output logic signed [15:0] u [4], input real s);
    real v [4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      v[i] = real'(int'($urandom_range(0, 65535)) - 32768);
      n = n + v[i] * v[i];
    end
    if (n < 1.0) begin
      v[0] = 1.0; n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) u[i] = clip16($rtoi(v[i] / n * 16384.0 * s));
  endtask

  task automatic random_item();
    logic [7:0][15:0] q;
    logic signed [15:0] ua [4];
    logic signed [15:0] ub [4];
    logic [14:0] t;
    int kind;
    int d;
    bit neg;
    kind = $urandom_range(0, 99);
    neg = 1'($urandom_range(0, 1));
    unit_quat(ua, 1.0);
    if (kind < 45) begin
      unit_quat(ub, 1.0);
    end else if (kind < 75) begin
      d = $urandom_range(1, 300);
      for (int i = 0; i < 4; i++) ub[i] = clip16(int'(ua[i]) + $urandom_range(0, 2 * d) - d);
    end else if (kind < 85) begin
      ub = ua;
    end else begin
      for (int i = 0; i < 4; i++) begin
        ua[i] = 16'($urandom_range(0, 65535));
        ub[i] = 16'($urandom_range(0, 65535));
      end
    end
    if (neg && kind < 85)
      for (int i = 0; i < 4; i++) ub[i] = clip16(-int'(ub[i]));
    for (int i = 0; i < 4; i++) begin
      q[i] = ua[i];
      q[4 + i] = ub[i];
    end
    d = $urandom_range(0, 19);
    if (d == 0) t = 15'd0;
    else if (d == 1) t = ONE_Q14;
    else if (d < 4) t = 15'($urandom_range(16385, 32767));
    else t = 15'($urandom_range(0, 16384));
    send_item(q, t);
  endtask

  task automatic directed_items();
    logic [7:0][15:0] q;
    q = {8{16'sh7fff}};        send_item(q, 15'd8192);
    q = {8{16'sh8000}};        send_item(q, 15'd8192);
    q = '0;                    send_item(q, 15'd0);
    q = {{4{16'sh8000}}, {4{16'sh7fff}}}; send_item(q, 15'h7fff);
    // Identical unit quaternions: dot of exactly one.
    q = {16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384};
    send_item(q, 15'd0); send_item(q, ONE_Q14); send_item(q, 15'd5000);
    // Opposite quaternions take the shorter arc.
    q = {16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384};
    send_item(q, 15'd8192);
    // Orthogonal pair.
    q = {16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'sd16384};
    send_item(q, 15'd0); send_item(q, 15'd8192); send_item(q, 15'h7fff);
    // Close pairs just above the default threshold.
    q = {16'd0, 16'd0, 16'sd300, 16'sd16381, 16'd0, 16'd0, 16'd0, 16'sd16384};
    send_item(q, 15'd4096);
    q = {16'd0, 16'd0, 16'sd100, 16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384};
    send_item(q, 15'd12000);
    // Dot well above one.
    q = {16'd0, 16'd0, 16'd0, 16'sh7fff, 16'd0, 16'd0, 16'd0, 16'sh7fff};
    send_item(q, 15'd3000);
    // Small values where the linear blend may vanish.
    q = {16'd0, 16'd0, 16'sd1, 16'sd0, 16'd0, 16'd0, 16'sd0, 16'sd1};
    send_item(q, 15'd8192);
    q = {16'd0, 16'd0, 16'd0, 16'sd1, 16'd0, 16'd0, 16'd0, 16'sd1};
    send_item(q, 15'd16000);
    q = {16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};
    send_item(q, 15'h5555);
    q = ~q;
    send_item(q, 15'h2aaa);
  endtask

  task automatic random_phase(input int n);
    repeat (n) random_item();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset threshold.
    directed_items();
    // Long receiver hold-off while the sender keeps offering.
    no_gaps = 1;
    hold_req = 1;
    random_phase(250);
    no_gaps = 0;
    random_phase(200);
    drain();

    // Threshold at one: the zero-sine case.
    write_thresh(ONE_Q14);
    directed_items();
    random_phase(350);
    drain();

    // Threshold at zero: linear path for any positive dot.
    write_thresh(15'd0);
    directed_items();
    random_phase(350);
    drain();

    write_thresh(15'd16383);
    random_phase(350);
    drain();

    write_thresh(15'($urandom_range(15000, 16384)));
    random_phase(300);
    drain();

    write_thresh(THRESH_RESET);
    random_phase(150);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
